### src/lpsf_pkg.sv
package lpsf_pkg;

  localparam logic [7:0] FlagByte  = 8'h7E;
  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] CtrlByte  = 8'h03;
  localparam logic [7:0] ChanReset = 8'h05;

  // Most bytes one input item can cause: flag, escaped channel, control, flag.
  localparam int unsigned MaxBurst = 5;
  localparam int unsigned CntW     = $clog2(MaxBurst + 1);
  localparam int unsigned IdxW     = $clog2(MaxBurst);

  localparam logic RegChannel = 1'b0;

  typedef enum logic [1:0] {
    PhHigh = 2'd0,
    PhLow  = 2'd1,
    PhData = 2'd2
  } phase_e;

  typedef struct packed {
    logic [MaxBurst-1:0][7:0] data;
    logic [MaxBurst-1:0]      fend;
    logic [CntW-1:0]          cnt;
  } burst_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FlagByte) || (b == EscByte);
  endfunction

endpackage

### src/length_prefix_to_sercomm_framer.sv
// An item sits in the input register right after its accepting edge; it is loaded into the
// shift buffer once that buffer is free, and its first result byte is then on the master side.
// The shift buffer sends one byte per cycle while the master side is ready; an item causes
// 0 to 5 result bytes (none for a high length byte), the next item waiting in the input register.
// Reset (async, active low): phase to expect high length byte, counters cleared,
// channel register to 5, all buffers empty.
module length_prefix_to_sercomm_framer import lpsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tuser,   // [0] frame_end
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] channel;
  logic       load;
  logic       emit_free;
  burst_t     burst;

  lpsf_apb_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .channel_o (channel)
  );

  lpsf_encoder u_enc (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .channel_i   (channel),
    .emit_free_i (emit_free),
    .load_o      (load),
    .burst_o     (burst)
  );

  lpsf_emitter u_emit (
    .clk_i,
    .rst_ni,
    .load_i      (load),
    .burst_i     (burst),
    .free_o      (emit_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .frame_end_o (m_axis_tuser),
    .last_o      (m_axis_tlast)
  );

endmodule

### src/lpsf_apb_regs.sv
module lpsf_apb_regs import lpsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  channel_o
);

  logic [7:0] channel_q, channel_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegChannel);

  always_comb begin
    channel_d = channel_q;
    if (wr_en) begin
      channel_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q <= ChanReset;
    end else begin
      channel_q <= channel_d;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegChannel) begin
      prdata = {24'd0, channel_q};
    end
  end

  assign channel_o = channel_q;

endmodule

### src/lpsf_encoder.sv
module lpsf_encoder import lpsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic [7:0] channel_i,
  input  logic       emit_free_i,
  output logic       load_o,
  output burst_t     burst_o
);

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q, in_byte_d;
  phase_e      phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] left_q, left_d;
  logic [15:0] left_new;
  logic [IdxW-1:0] n;
  logic        take_in;

  assign load_o     = in_vld_q && emit_free_i;
  assign in_ready_o = !in_vld_q || load_o;
  assign take_in    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    if (take_in) begin
      in_vld_d  = 1'b1;
      in_byte_d = in_byte_i;
    end else if (load_o) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    burst_o  = '0;
    n        = '0;
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    left_d   = left_q;
    left_new = left_q;
    case (phase_q)
      PhLow: begin
        left_new = {len_hi_q, in_byte_q};
        burst_o.data[n] = FlagByte;
        n = n + 1'b1;
        if (needs_escape(channel_i)) begin
          burst_o.data[n] = EscByte;
          n = n + 1'b1;
          burst_o.data[n] = channel_i ^ EscXor;
        end else begin
          burst_o.data[n] = channel_i;
        end
        n = n + 1'b1;
        // Control byte is never a flag or escape code.
        burst_o.data[n] = CtrlByte;
        n = n + 1'b1;
        if (left_new == 16'd0) begin
          burst_o.data[n] = FlagByte;
          burst_o.fend[n] = 1'b1;
          n = n + 1'b1;
          phase_d = PhHigh;
        end else begin
          phase_d = PhData;
        end
        left_d = left_new;
      end
      PhData: begin
        left_new = left_q - 16'd1;
        if (needs_escape(in_byte_q)) begin
          burst_o.data[n] = EscByte;
          n = n + 1'b1;
          burst_o.data[n] = in_byte_q ^ EscXor;
        end else begin
          burst_o.data[n] = in_byte_q;
        end
        n = n + 1'b1;
        if (left_new == 16'd0) begin
          burst_o.data[n] = FlagByte;
          burst_o.fend[n] = 1'b1;
          n = n + 1'b1;
          phase_d = PhHigh;
        end
        left_d = left_new;
      end
      default: begin
        len_hi_d = in_byte_q;
        phase_d  = PhLow;
      end
    endcase
    burst_o.cnt = CntW'(n);
    if (!load_o) begin
      phase_d  = phase_q;
      len_hi_d = len_hi_q;
      left_d   = left_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= PhHigh;
      len_hi_q <= 8'd0;
      left_q   <= 16'd0;
    end else begin
      in_vld_q <= in_vld_d;
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

endmodule

### src/lpsf_emitter.sv
module lpsf_emitter import lpsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       frame_end_o,
  output logic       last_o
);

  logic [MaxBurst-1:0][7:0] data_q, data_d;
  logic [MaxBurst-1:0]      fend_q, fend_d;
  logic [CntW-1:0]          rem_q, rem_d;
  logic                     take;

  assign out_valid_o = (rem_q != '0);
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = (rem_q == '0) || ((rem_q == CntW'(1)) && out_ready_i);
  assign out_byte_o  = data_q[0];
  assign frame_end_o = fend_q[0];
  assign last_o      = (rem_q == CntW'(1));

  always_comb begin
    data_d = data_q;
    fend_d = fend_q;
    rem_d  = rem_q;
    if (load_i) begin
      data_d = burst_i.data;
      fend_d = burst_i.fend;
      rem_d  = burst_i.cnt;
    end else if (take) begin
      // Advance: shift the next byte down to the head.
      for (int i = 0; i < MaxBurst - 1; i++) begin
        data_d[i] = data_q[i+1];
        fend_d[i] = fend_q[i+1];
      end
      rem_d = rem_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    fend_q <= fend_d;
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= CntW'(MaxBurst))
    else $error("burst count beyond maximum");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && (burst_i.cnt != '0) |=> out_valid_o)
    else $error("loaded burst not presented");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> last_o && (out_byte_o == FlagByte))
    else $error("closing flag not last byte of its item");

endmodule

### test/testbench.sv
module testbench;
  import lpsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned PhaseItems = 12;
  localparam logic [2:0]  ChanAddr   = {RegChannel, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic       last;
  } frame_byte_t;

  typedef struct {
    logic [7:0] b;
    int         n;      // -1: take the bytes from the framer model
    logic [7:0] d [5];
    bit         closes;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [7:0] out_byte
  logic        m_axis_tuser;          // [0] frame_end
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  length_prefix_to_sercomm_framer dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // Framer model state
  phase_e      parse_ph = PhHigh;
  logic [7:0]  len_hi = 8'h00;
  logic [15:0] bytes_left = 16'h0000;
  logic [7:0]  chan_id = ChanReset;

  frame_byte_t step_q[$];
  frame_byte_t frame_q[$];

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned phase_items = 0;
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  function automatic void put_raw(input logic [7:0] b, input logic fend);
    step_q.push_back('{data: b, fend: fend, last: 1'b0});
  endfunction

  function automatic void put_stuffed(input logic [7:0] b);
    if (b == FlagByte || b == EscByte) begin
      put_raw(EscByte, 1'b0);
      put_raw(b ^ EscXor, 1'b0);
    end else begin
      put_raw(b, 1'b0);
    end
  endfunction

  // Advance the model by one input byte; the frame bytes it causes land in step_q.
  function automatic void frame_step(input logic [7:0] b);
    step_q.delete();
    case (parse_ph)
      PhLow: begin
        bytes_left = {len_hi, b};
        put_raw(FlagByte, 1'b0);
        put_stuffed(chan_id);
        put_stuffed(CtrlByte);
        if (bytes_left == 16'h0000) begin
          put_raw(FlagByte, 1'b1);
          parse_ph = PhHigh;
        end else begin
          parse_ph = PhData;
        end
      end
      PhData: begin
        put_stuffed(b);
        bytes_left = bytes_left - 16'h0001;
        if (bytes_left == 16'h0000) begin
          put_raw(FlagByte, 1'b1);
          parse_ph = PhHigh;
        end
      end
      default: begin
        len_hi = b;
        parse_ph = PhLow;
      end
    endcase
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
  endfunction

  // Offer one item, idling between bursts, and return at the edge that takes it.
  task automatic send_item(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    burst_left--;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
  endtask

  task automatic feed(input logic [7:0] b);
    send_item(b);
    frame_step(b);
    foreach (step_q[i]) frame_q.push_back(step_q[i]);
    phase_items++;
  endtask

  task automatic send_msg(input logic [15:0] len);
    logic [7:0] pb;
    feed(len[15:8]);
    feed(len[7:0]);
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    pb = FlagByte;
        2:       pb = EscByte;
        default: pb = 8'($urandom_range(0, 255));
      endcase
      feed(pb);
    end
  endtask

  // Stop offering, drain every frame byte, then cover a high length byte still in flight.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Optionally write the channel register, then read it back.
  task automatic chan_access(input bit wr, input logic [7:0] val);
    for (int k = (wr ? 0 : 1); k < 2; k++) begin
      @(negedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (k == 0);
      paddr   <= ChanAddr;
      pwdata  <= {24'h0, val};
      @(negedge clk_i);
      penable <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (pready) break;
      end
      if (k == 0) begin
        chan_id = val;
      end else if (prdata !== {24'h0, chan_id}) begin
        mismatches++;
        $display("%0t: channel readback expected %h actual %h", $time, chan_id, prdata);
      end
      @(negedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
    end
  endtask

  dir_row_t dir_tab [20] = '{
    '{b: 8'h00, n: 0,  d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    // empty message: header then closing flag at once
    '{b: 8'h00, n: 4,  d: '{8'h7E, 8'h05, 8'h03, 8'h7E, 8'h00}, closes: 1'b1},
    '{b: 8'h00, n: 0,  d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h06, n: 3,  d: '{8'h7E, 8'h05, 8'h03, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h7E, n: 2,  d: '{8'h7D, 8'h5E, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h7D, n: 2,  d: '{8'h7D, 8'h5D, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h00, n: 1,  d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h5E, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h80, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'hFF, n: 2,  d: '{8'hFF, 8'h7E, 8'h00, 8'h00, 8'h00}, closes: 1'b1},
    '{b: 8'h00, n: 0,  d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h01, n: 3,  d: '{8'h7E, 8'h05, 8'h03, 8'h00, 8'h00}, closes: 1'b0},
    // escaped last payload byte, then closing flag
    '{b: 8'h7E, n: 3,  d: '{8'h7D, 8'h5E, 8'h7E, 8'h00, 8'h00}, closes: 1'b1},
    '{b: 8'h00, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h02, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h7F, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h01, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h00, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h01, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0},
    '{b: 8'h20, n: -1, d: '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, closes: 1'b0}
  };

  logic [7:0] chan_tab [6];

  initial begin
    chan_tab = '{ChanReset, 8'h00, 8'hFF, FlagByte, EscByte, 8'($urandom_range(0, 255))};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    chan_access(1'b0, 8'h00);

    foreach (dir_tab[r]) begin
      send_item(dir_tab[r].b);
      frame_step(dir_tab[r].b);
      if (dir_tab[r].n < 0) begin
        foreach (step_q[i]) frame_q.push_back(step_q[i]);
      end else begin
        for (int i = 0; i < dir_tab[r].n; i++) begin
          frame_q.push_back('{data: dir_tab[r].d[i],
                              fend: dir_tab[r].closes && (i == dir_tab[r].n - 1),
                              last: (i == dir_tab[r].n - 1)});
        end
      end
    end

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        settle();
        chan_access(1'b1, chan_tab[p]);
      end
      phase_items = 0;
      if (p == 2) begin
        // stall the output while a long frame pours in
        hold_req = 1'b1;
        send_msg(16'h0100 + 16'($urandom_range(0, 15)));
      end
      while (phase_items < PhaseItems) begin
        case ($urandom_range(0, 9))
          0:       send_msg(16'h0000);
          1:       send_msg(16'($urandom_range(9, 40)));
          default: send_msg(16'($urandom_range(1, 8)));
        endcase
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: stall pattern picked per window, plus one long hold-off on request.
  initial begin
    int unsigned mode;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    frame_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte expected none actual data %h fend %b last %b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end else begin
        want = frame_q.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tuser !== want.fend ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          $display("%0t: expected data %h fend %b last %b actual data %h fend %b last %b",
                   $time, want.data, want.fend, want.last,
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

### filelist.f
src/lpsf_pkg.sv
src/lpsf_apb_regs.sv
src/lpsf_encoder.sv
src/lpsf_emitter.sv
src/length_prefix_to_sercomm_framer.sv
test/testbench.sv
